FILE: design/afr_pkg.sv
// shared types, register map and constants of the association field rescorer
package afr_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register indexes, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_SCORE_THRESHOLD    = 3'd0,
    REG_CONFIDENCE_FLOOR   = 3'd1,
    REG_GRID_STRIDE        = 3'd2,
    REG_MAP_OFFSET         = 3'd3,
    REG_RESCORE_ENABLE     = 3'd4,
    REG_MAP_KEYPOINTS_USED = 3'd5,
    REG_MAP_ROWS_USED      = 3'd6,
    REG_MAP_COLS_USED      = 3'd7
  } reg_idx_e;

  localparam logic [15:0] SCORE_THRESHOLD_RST    = 16'd19661;
  localparam logic [15:0] CONFIDENCE_FLOOR_RST   = 16'd0;
  localparam logic [4:0]  GRID_STRIDE_RST        = 5'd8;
  localparam logic [15:0] MAP_OFFSET_RST         = 16'd0;
  localparam logic        RESCORE_ENABLE_RST     = 1'b1;
  localparam logic [5:0]  MAP_KEYPOINTS_USED_RST = 6'd17;
  localparam logic [6:0]  MAP_ROWS_USED_RST      = 7'd64;
  localparam logic [6:0]  MAP_COLS_USED_RST      = 7'd64;

  // lookup window in 1/256 pixel: p >= -125 and p <= n*256 - 131
  localparam logic signed [19:0] LOOKUP_MIN  = -20'sd125;
  localparam logic signed [20:0] EDGE_MARGIN = 21'sd131;
  localparam logic signed [19:0] ROUND_HALF  = 20'sd128;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic        func;
    logic [16:0] map_address;
    logic [15:0] score;
    logic [5:0]  connection;
    logic [4:0]  from_keypoint;
    logic [4:0]  to_keypoint;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [15:0] start_scale;
    logic [15:0] end_scale;
  } in_item_t;

  typedef struct packed {
    logic        direction;
    logic [5:0]  field_number;
    logic [15:0] rescored;
    logic signed [19:0] near_x;
    logic signed [19:0] near_y;
    logic signed [19:0] far_x;
    logic signed [19:0] far_y;
    logic [19:0] near_scale;
    logic [19:0] far_scale;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] score_threshold;
    logic [15:0] confidence_floor;
    logic [4:0]  grid_stride;
    logic [15:0] map_offset;
    logic        rescore_enable;
    logic [5:0]  map_keypoints_used;
    logic [6:0]  map_rows_used;
    logic [6:0]  map_cols_used;
  } cfg_t;

  // cell geometry after stride scaling
  typedef struct packed {
    logic [5:0]  field_number;
    logic [15:0] conf;
    logic signed [19:0] sx;
    logic signed [19:0] sy;
    logic signed [19:0] ex;
    logic signed [19:0] ey;
    logic [19:0] ss;
    logic [19:0] es;
  } cell_t;

  // per-cell control after the address stage
  typedef struct packed {
    logic keep;
    logic oob_fwd;
    logic oob_bwd;
  } probe_t;

endpackage

FILE: design/association_field_rescorer.sv
// Association field rescorer: map writes and cell requests in, scored associations out.
// Input requests (in_valid_i/in_ready_o) either store one Q4.12 map entry (func 0)
// or carry one field cell (func 1). A kept cell yields up to two results on
// out_valid_o/out_ready_i: forward first, then backward, last set on the final one.
// A result passes stages 1 to 4 and then the output register before it is presented;
// a second result of the same cell follows once the first has been taken.
// Throughput: one request per cycle while the receiver keeps up; a cell with two
// results holds the pipeline while its first result moves out, since the output register takes one result per cycle.
// The pipeline is stage 1 stride scaling, stage 2 map address and bounds,
// registered map read, stage 3 rescoring factor, stage 4 confidence scaling.
// Map writes take effect as they leave stage 1, ahead of any later cell.
// When the receiver stalls while a result waits in stage 4, every stage holds its contents and in_ready_o drops.
// Reset empties the pipeline and loads the register defaults; the map memory
// is not cleared and holds unknown data until written.
// Registers sit on an APB port at byte address 4*index, pready tied high.
module association_field_rescorer #(
  parameter int KEYPOINT_PLANES = 32,
  parameter int MAP_HEIGHT = 64,
  parameter int MAP_WIDTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [afr_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [afr_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [afr_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  afr_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output afr_pkg::out_item_t                  out_data_o
);

  import afr_pkg::*;

  localparam int DEPTH = KEYPOINT_PLANES * MAP_HEIGHT * MAP_WIDTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  logic          adv;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr_fwd;
  logic [AW-1:0] ram_raddr_bwd;
  logic [15:0]   ram_rdata_fwd;
  logic [15:0]   ram_rdata_bwd;
  probe_t        s2_probe;
  cell_t         s2_cell;
  logic [15:0]   fwd_rescored;
  logic          fwd_pass;
  logic [15:0]   bwd_rescored;
  logic          bwd_pass;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold    <= SCORE_THRESHOLD_RST;
      cfg_q.confidence_floor   <= CONFIDENCE_FLOOR_RST;
      cfg_q.grid_stride        <= GRID_STRIDE_RST;
      cfg_q.map_offset         <= MAP_OFFSET_RST;
      cfg_q.rescore_enable     <= RESCORE_ENABLE_RST;
      cfg_q.map_keypoints_used <= MAP_KEYPOINTS_USED_RST;
      cfg_q.map_rows_used      <= MAP_ROWS_USED_RST;
      cfg_q.map_cols_used      <= MAP_COLS_USED_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SCORE_THRESHOLD:    cfg_q.score_threshold    <= pwdata[15:0];
        REG_CONFIDENCE_FLOOR:   cfg_q.confidence_floor   <= pwdata[15:0];
        REG_GRID_STRIDE:        cfg_q.grid_stride        <= pwdata[4:0];
        REG_MAP_OFFSET:         cfg_q.map_offset         <= pwdata[15:0];
        REG_RESCORE_ENABLE:     cfg_q.rescore_enable     <= pwdata[0];
        REG_MAP_KEYPOINTS_USED: cfg_q.map_keypoints_used <= pwdata[5:0];
        REG_MAP_ROWS_USED:      cfg_q.map_rows_used      <= pwdata[6:0];
        REG_MAP_COLS_USED:      cfg_q.map_cols_used      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCORE_THRESHOLD:    prdata = 32'(cfg_q.score_threshold);
      REG_CONFIDENCE_FLOOR:   prdata = 32'(cfg_q.confidence_floor);
      REG_GRID_STRIDE:        prdata = 32'(cfg_q.grid_stride);
      REG_MAP_OFFSET:         prdata = 32'(cfg_q.map_offset);
      REG_RESCORE_ENABLE:     prdata = 32'(cfg_q.rescore_enable);
      REG_MAP_KEYPOINTS_USED: prdata = 32'(cfg_q.map_keypoints_used);
      REG_MAP_ROWS_USED:      prdata = 32'(cfg_q.map_rows_used);
      REG_MAP_COLS_USED:      prdata = 32'(cfg_q.map_cols_used);
      default:                prdata = '0;
    endcase
  end

  assign in_ready_o = adv;

  afr_front #(
    .KEYPOINT_PLANES(KEYPOINT_PLANES),
    .MAP_HEIGHT     (MAP_HEIGHT),
    .MAP_WIDTH      (MAP_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .adv_i          (adv),
    .in_valid_i     (in_valid_i),
    .in_data_i      (in_data_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_fwd_o(ram_raddr_fwd),
    .ram_raddr_bwd_o(ram_raddr_bwd),
    .s2_probe_o     (s2_probe),
    .s2_cell_o      (s2_cell)
  );

  afr_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_map (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .re_i     (adv),
    .raddr_a_i(ram_raddr_fwd),
    .raddr_b_i(ram_raddr_bwd),
    .rdata_a_o(ram_rdata_fwd),
    .rdata_b_o(ram_rdata_bwd)
  );

  afr_rescore u_rescore_fwd (
    .clk_i     (clk_i),
    .cfg_i     (cfg_q),
    .adv_i     (adv),
    .map_i     (ram_rdata_fwd),
    .oob_i     (s2_probe.oob_fwd),
    .conf_i    (s2_cell.conf),
    .rescored_o(fwd_rescored),
    .pass_o    (fwd_pass)
  );

  afr_rescore u_rescore_bwd (
    .clk_i     (clk_i),
    .cfg_i     (cfg_q),
    .adv_i     (adv),
    .map_i     (ram_rdata_bwd),
    .oob_i     (s2_probe.oob_bwd),
    .conf_i    (s2_cell.conf),
    .rescored_o(bwd_rescored),
    .pass_o    (bwd_pass)
  );

  afr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s2_keep_i     (s2_probe.keep),
    .s2_cell_i     (s2_cell),
    .fwd_rescored_i(fwd_rescored),
    .fwd_pass_i    (fwd_pass),
    .bwd_rescored_i(bwd_rescored),
    .bwd_pass_i    (bwd_pass),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

FILE: design/afr_ram.sv
// generic single-write dual-read ram with registered read data
module afr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: design/afr_front.sv
// input stage with stride scaling, then bounds check and map address generation
module afr_front #(
  parameter int KEYPOINT_PLANES = 32,
  parameter int MAP_HEIGHT = 64,
  parameter int MAP_WIDTH = 64,
  localparam int DEPTH = KEYPOINT_PLANES * MAP_HEIGHT * MAP_WIDTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afr_pkg::cfg_t     cfg_i,
  input  logic              adv_i,
  input  logic              in_valid_i,
  input  afr_pkg::in_item_t in_data_i,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [15:0]       ram_wdata_o,
  output logic [AW-1:0]     ram_raddr_fwd_o,
  output logic [AW-1:0]     ram_raddr_bwd_o,
  output afr_pkg::probe_t   s2_probe_o,
  output afr_pkg::cell_t    s2_cell_o
);

  import afr_pkg::*;

  function automatic logic signed [19:0] scale_coord(logic signed [15:0] x, logic [4:0] st);
    logic signed [21:0] p;
    p = $signed({{6{x[15]}}, x}) * $signed({17'b0, st});
    if (p > 22'sd524287) begin
      return 20'sd524287;
    end else if (p < -22'sd524288) begin
      return -20'sd524288;
    end
    return $signed(p[19:0]);
  endfunction

  function automatic logic [19:0] scale_size(logic [15:0] s, logic [4:0] st);
    logic [20:0] p;
    p = {5'b0, s} * {16'b0, st};
    return p[20] ? 20'hfffff : p[19:0];
  endfunction

  function automatic logic in_window(logic signed [19:0] p, logic [6:0] n);
    logic signed [20:0] lim;
    lim = $signed({6'b0, n, 8'b0}) - EDGE_MARGIN;
    return (p >= LOOKUP_MIN) && ($signed({p[19], p}) <= lim);
  endfunction

  function automatic logic [AW-1:0] map_index(logic [4:0] plane, logic signed [19:0] px,
                                                logic signed [19:0] py);
    logic [19:0] tx;
    logic [19:0] ty;
    tx = px + ROUND_HALF;
    ty = py + ROUND_HALF;
    return AW'((AW'(plane) * AW'(MAP_HEIGHT) + AW'(ty[14:8])) * AW'(MAP_WIDTH)
               + AW'(tx[14:8]));
  endfunction

  logic        s1_wr_q;
  logic        s1_keep_q;
  cell_t       s1_cell_q;
  logic [4:0]  s1_from_q;
  logic [4:0]  s1_to_q;
  logic [16:0] s1_addr_q;
  logic [15:0] s1_wdata_q;
  probe_t      s2_probe_q;
  probe_t      s2_probe_d;
  cell_t       s2_cell_q;

  logic [6:0] rows_eff;
  logic [6:0] cols_eff;
  logic [6:0] planes_eff;

  // stage 1: capture and scale by the grid stride
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_wr_q   <= 1'b0;
      s1_keep_q <= 1'b0;
    end else if (adv_i) begin
      s1_wr_q   <= in_valid_i && !in_data_i.func;
      s1_keep_q <= in_valid_i && in_data_i.func
                   && (in_data_i.score >= cfg_i.score_threshold);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_cell_q.field_number <= in_data_i.connection;
      s1_cell_q.conf         <= in_data_i.score;
      s1_cell_q.sx           <= scale_coord(in_data_i.start_x, cfg_i.grid_stride);
      s1_cell_q.sy           <= scale_coord(in_data_i.start_y, cfg_i.grid_stride);
      s1_cell_q.ex           <= scale_coord(in_data_i.end_x, cfg_i.grid_stride);
      s1_cell_q.ey           <= scale_coord(in_data_i.end_y, cfg_i.grid_stride);
      s1_cell_q.ss           <= scale_size(in_data_i.start_scale, cfg_i.grid_stride);
      s1_cell_q.es           <= scale_size(in_data_i.end_scale, cfg_i.grid_stride);
      s1_from_q              <= in_data_i.from_keypoint;
      s1_to_q                <= in_data_i.to_keypoint;
      s1_addr_q              <= in_data_i.map_address;
      s1_wdata_q             <= in_data_i.score;
    end
  end

  // map sizes clamped to the built storage
  assign rows_eff   = (32'(cfg_i.map_rows_used) < MAP_HEIGHT) ? cfg_i.map_rows_used
                                                               : 7'(MAP_HEIGHT);
  assign cols_eff   = (32'(cfg_i.map_cols_used) < MAP_WIDTH) ? cfg_i.map_cols_used
                                                              : 7'(MAP_WIDTH);
  assign planes_eff = (32'(cfg_i.map_keypoints_used) < KEYPOINT_PLANES)
                      ? {1'b0, cfg_i.map_keypoints_used} : 7'(KEYPOINT_PLANES);

  always_comb begin
    s2_probe_d.keep    = s1_keep_q;
    s2_probe_d.oob_fwd = !(({2'b0, s1_to_q} < planes_eff)
                           && in_window(s1_cell_q.ex, cols_eff)
                           && in_window(s1_cell_q.ey, rows_eff));
    s2_probe_d.oob_bwd = !(({2'b0, s1_from_q} < planes_eff)
                           && in_window(s1_cell_q.sx, cols_eff)
                           && in_window(s1_cell_q.sy, rows_eff));
  end

  // map writes land as the item leaves stage 1, so later cells see them
  assign ram_we_o        = adv_i && s1_wr_q && (32'(s1_addr_q) < DEPTH);
  assign ram_waddr_o     = AW'(s1_addr_q);
  assign ram_wdata_o     = s1_wdata_q;
  assign ram_raddr_fwd_o = map_index(s1_to_q, s1_cell_q.ex, s1_cell_q.ey);
  assign ram_raddr_bwd_o = map_index(s1_from_q, s1_cell_q.sx, s1_cell_q.sy);

  // stage 2: aligned with the registered map read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_probe_q <= '0;
    end else if (adv_i) begin
      s2_probe_q <= s2_probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_cell_q <= s1_cell_q;
    end
  end

  assign s2_probe_o = s2_probe_q;
  assign s2_cell_o  = s2_cell_q;

endmodule

FILE: design/afr_rescore.sv
// one lookup direction: offset removal, rescoring factor and confidence scaling
module afr_rescore (
  input  logic          clk_i,
  input  afr_pkg::cfg_t cfg_i,
  input  logic          adv_i,
  input  logic [15:0]   map_i,
  input  logic          oob_i,
  input  logic [15:0]   conf_i,
  output logic [15:0]   rescored_o,
  output logic          pass_o
);

  import afr_pkg::*;

  logic [15:0] value;
  logic [16:0] weight;
  logic [32:0] factor_d;
  logic [32:0] factor_q;
  logic [15:0] conf_q;
  logic [48:0] product;
  logic [20:0] scaled;
  logic [15:0] saturated;

  always_comb begin
    if (oob_i || (map_i < cfg_i.map_offset)) begin
      value = '0;
    end else begin
      value = map_i - cfg_i.map_offset;
    end
    weight   = ONE_Q16 - {1'b0, cfg_i.confidence_floor};
    // floor*4096 + (1 - floor)*v, Q0.16 times Q4.12
    factor_d = 33'({cfg_i.confidence_floor, 12'b0}) + 33'(weight) * 33'(value);
  end

  // stage 3
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      factor_q <= factor_d;
      conf_q   <= conf_i;
    end
  end

  assign product   = 49'(conf_q) * 49'(factor_q);
  assign scaled    = product[48:28];
  assign saturated = (|scaled[20:16]) ? 16'hffff : scaled[15:0];
  assign rescored_o = cfg_i.rescore_enable ? saturated : conf_q;
  assign pass_o     = rescored_o > cfg_i.score_threshold;

endmodule

FILE: design/afr_emit.sv
// geometry pipeline, result sequencing and output register
module afr_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s2_keep_i,
  input  afr_pkg::cell_t     s2_cell_i,
  input  logic [15:0]        fwd_rescored_i,
  input  logic               fwd_pass_i,
  input  logic [15:0]        bwd_rescored_i,
  input  logic               bwd_pass_i,
  output logic               adv_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afr_pkg::out_item_t out_data_o
);

  import afr_pkg::*;

  logic      s3_keep_q;
  cell_t     s3_cell_q;
  logic      fwd_pend_q;
  logic      bwd_pend_q;
  cell_t     s4_cell_q;
  logic [15:0] s4_fwd_q;
  logic [15:0] s4_bwd_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      pend_any;
  logic      load;

  assign pend_any = fwd_pend_q || bwd_pend_q;
  assign load     = pend_any && (!out_valid_q || out_ready_i);
  // the emit stage frees up once its last pending result moves out
  assign adv_o    = !pend_any || (load && !(fwd_pend_q && bwd_pend_q));

  always_comb begin
    result.field_number = s4_cell_q.field_number;
    if (fwd_pend_q) begin
      result.direction  = 1'b0;
      result.rescored   = s4_fwd_q;
      result.near_x     = s4_cell_q.sx;
      result.near_y     = s4_cell_q.sy;
      result.far_x      = s4_cell_q.ex;
      result.far_y      = s4_cell_q.ey;
      result.near_scale = s4_cell_q.ss;
      result.far_scale  = s4_cell_q.es;
      result.last       = !bwd_pend_q;
    end else begin
      result.direction  = 1'b1;
      result.rescored   = s4_bwd_q;
      result.near_x     = s4_cell_q.ex;
      result.near_y     = s4_cell_q.ey;
      result.far_x      = s4_cell_q.sx;
      result.far_y      = s4_cell_q.sy;
      result.near_scale = s4_cell_q.es;
      result.far_scale  = s4_cell_q.ss;
      result.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_keep_q   <= 1'b0;
      fwd_pend_q  <= 1'b0;
      bwd_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_o) begin
        s3_keep_q  <= s2_keep_i;
        fwd_pend_q <= s3_keep_q && fwd_pass_i;
        bwd_pend_q <= s3_keep_q && bwd_pass_i;
      end else if (load && fwd_pend_q) begin
        fwd_pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s3_cell_q <= s2_cell_i;
      s4_cell_q <= s3_cell_q;
      s4_fwd_q  <= fwd_rescored_i;
      s4_bwd_q  <= bwd_rescored_i;
    end
    if (load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
